@@ hdl/gtwp_pkg.sv @@
// Package for the greedy two-way partition block.
// Holds sizes, widths and the item and result types used across the modules.
// No dependencies.
`default_nettype none

package gtwp_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int WEIGHT_W  = 16;
    localparam int SUM_W     = 21;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int ACC_W     = WEIGHT_W + CNT_W;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int TDATA_W   = ((WEIGHT_W + 1 + 2 * SUM_W + 7) / 8) * 8;

    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [ACC_W-1:0]    t_acc;

    localparam t_cnt MAX_CNT = t_cnt'(MAX_ITEMS);

    typedef struct packed {
        t_weight weight;
        logic    overflow;
        logic    last;
    } t_entry;

    typedef struct packed {
        t_weight           weight;
        logic              side;
        logic [SUM_W-1:0]  sum_a;
        logic [SUM_W-1:0]  sum_b;
        logic              overflow;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/greedy_two_way_partition.sv @@
// Top level of the greedy two-way partition block.
// Instantiates gtwp_front, gtwp_fifo and gtwp_back; depends on gtwp_pkg.
//
// Weights of a set are taken one per cycle, each inserted at once into a
// row of 32 sorted cells; the item marked last closes the set, and weights
// beyond 32 are dropped and reported as overflow. The cells then drain one
// per cycle, unless the queue is full, through a four-entry queue into the
// unit that assigns each weight to side A when A's sum is at most B's, else
// to side B. No new weight is taken until the set has drained; results leave
// at one per cycle when the sink is ready, the last one marked by tlast.
`default_nettype none

module greedy_two_way_partition (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [15:0]                       s_axis_tdata,  // weight[15:0]
    input  wire                              s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // item_weight[15:0], side[16], sum_a[37:17], sum_b[58:38], zeros above.
    output logic [gtwp_pkg::TDATA_W-1:0]     m_axis_tdata,
    output logic                             m_axis_tuser,  // overflow[0]
    output logic                             m_axis_tlast
);
    import gtwp_pkg::*;

    logic    w_push, w_full, w_pop, w_nonempty;
    t_entry  w_in_entry, w_out_entry;
    t_result w_result;

    gtwp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_weight (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_ready  (s_axis_tready),
        .o_push   (w_push),
        .o_entry  (w_in_entry),
        .i_full   (w_full)
    );

    gtwp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_entry    (w_in_entry),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_entry    (w_out_entry),
        .o_nonempty (w_nonempty)
    );

    gtwp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (w_nonempty),
        .i_entry    (w_out_entry),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (w_result)
    );

    assign m_axis_tdata = TDATA_W'({w_result.sum_b, w_result.sum_a,
                                    w_result.side, w_result.weight});
    assign m_axis_tuser = w_result.overflow;
    assign m_axis_tlast = w_result.last;

endmodule

`default_nettype wire

@@ hdl/gtwp_front.sv @@
// Front part: accepts weights and keeps them in a row of sorted cells.
// After the last item it drains the cells, largest first, into the queue.
// Depends on gtwp_pkg.
`default_nettype none

module gtwp_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire gtwp_pkg::t_weight  i_weight,
    input  wire                     i_last,
    output logic                    o_ready,
    output logic                    o_push,
    output gtwp_pkg::t_entry        o_entry,
    input  wire                     i_full
);
    import gtwp_pkg::*;

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic    r_state, n_state;
    t_cnt    r_count, n_count;
    logic    r_drop, n_drop;
    t_weight r_cell [MAX_ITEMS];
    t_weight n_cell [MAX_ITEMS];
    logic    v_gt   [MAX_ITEMS];
    logic    v_acc;

    assign o_ready = (r_state == ST_LOAD);
    assign v_acc   = i_valid && o_ready;
    assign o_push  = (r_state == ST_DRAIN) && !i_full;

    always_comb begin
        o_entry.weight   = r_cell[0];
        o_entry.overflow = r_drop;
        o_entry.last     = (r_count == t_cnt'(1));
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        for (int i = 0; i < MAX_ITEMS; i++) begin
            v_gt[i]   = (t_cnt'(i) >= r_count) || (i_weight > r_cell[i]);
            n_cell[i] = r_cell[i];
        end
        unique case (r_state)
            ST_LOAD: begin
                if (v_acc) begin
                    if (r_count != MAX_CNT) begin
                        n_count = r_count + t_cnt'(1);
                        if (v_gt[0]) begin
                            n_cell[0] = i_weight;
                        end
                        for (int i = 1; i < MAX_ITEMS; i++) begin
                            if (v_gt[i]) begin
                                n_cell[i] = v_gt[i-1] ? r_cell[i-1] : i_weight;
                            end
                        end
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (o_push) begin
                    for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                        n_cell[i] = r_cell[i+1];
                    end
                    n_count = r_count - t_cnt'(1);
                    if (r_count == t_cnt'(1)) begin
                        n_state = ST_LOAD;
                        n_drop  = 1'b0;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

endmodule

`default_nettype wire

@@ hdl/gtwp_fifo.sv @@
// Short queue of sorted entries between the front and back parts.
// Depends on gtwp_pkg.
`default_nettype none

module gtwp_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire gtwp_pkg::t_entry i_entry,
    output logic                o_full,
    input  wire                 i_pop,
    output gtwp_pkg::t_entry    o_entry,
    output logic                o_nonempty
);
    import gtwp_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_cnt;

    assign o_full     = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_entry    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QPTR_W + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

@@ hdl/gtwp_back.sv @@
// Back part: assigns each sorted weight to the side with the smaller sum,
// side A on a tie, and holds the result in an output register. Depends on gtwp_pkg.
`default_nettype none

module gtwp_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_nonempty,
    input  wire gtwp_pkg::t_entry i_entry,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire                   i_ready,
    output gtwp_pkg::t_result     o_result
);
    import gtwp_pkg::*;

    t_acc    r_sa, r_sb, n_sa, n_sb;
    logic    r_valid;
    t_result r_out, n_out;

    assign o_pop    = i_nonempty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    always_comb begin
        n_sa = r_sa;
        n_sb = r_sb;
        if (r_sa <= r_sb) begin
            n_sa = r_sa + t_acc'(i_entry.weight);
        end else begin
            n_sb = r_sb + t_acc'(i_entry.weight);
        end
        n_out.weight   = i_entry.weight;
        n_out.side     = !(r_sa <= r_sb);
        n_out.sum_a    = n_sa[SUM_W-1:0];
        n_out.sum_b    = n_sb[SUM_W-1:0];
        n_out.overflow = i_entry.overflow;
        n_out.last     = i_entry.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sa    <= '0;
            r_sb    <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_sa    <= i_entry.last ? '0 : n_sa;
                r_sb    <= i_entry.last ? '0 : n_sb;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

@@ hdl/gtwp_checker.sv @@
// Port-level checker for the greedy two-way partition block, with its bind.
// Depends on gtwp_pkg.
`default_nettype none

module gtwp_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          s_axis_tvalid,
    input wire                          s_axis_tready,
    input wire [15:0]                   s_axis_tdata,
    input wire                          s_axis_tlast,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [gtwp_pkg::TDATA_W-1:0]  m_axis_tdata,
    input wire                          m_axis_tuser,
    input wire                          m_axis_tlast
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result request shown right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result request changed");

    a_side_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[16] == 1'b0 && m_axis_tdata[37:17] >= 21'(m_axis_tdata[15:0]))
            || (m_axis_tdata[16] == 1'b1
                && m_axis_tdata[58:38] >= 21'(m_axis_tdata[15:0])))
        else $error("chosen side sum smaller than its weight");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken while a closed set is draining");

endmodule

bind greedy_two_way_partition gtwp_checker u_gtwp_checker (.*);

`default_nettype wire
